[hw/rtl/tdb_pkg.sv]
// shared types and default constants for the on-delay timer bank
package tdb_pkg;

  localparam int TIMERS_DEF    = 16;
  localparam int TIME_BITS_DEF = 32;

  localparam int INDEX_W  = 4;
  localparam int PRESET_W = 15;
  localparam int NOW_W    = 32;

  // update decision for the timer entry in the evaluate stage
  typedef struct packed {
    logic wr_flags;
    logic sess_val;
    logic done_val;
    logic start_wr;
    logic done_res;
  } tdb_upd_t;

endpackage

[hw/rtl/tdb_start_mem.sv]
// start time memory: one write port, one registered read port
module tdb_start_mem #(
  parameter int DEPTH  = tdb_pkg::TIMERS_DEF,
  parameter int DATA_W = tdb_pkg::TIME_BITS_DEF,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/tdb_eval.sv]
// per-access timer decision: session start, latch, elapsed compare, clear
module tdb_eval #(
  parameter int TIME_BITS = tdb_pkg::TIME_BITS_DEF
) (
  input  logic                          in_range,
  input  logic                          enable,
  input  logic                          sess,
  input  logic                          done,
  input  logic [TIME_BITS-1:0]          start_time,
  input  logic [TIME_BITS-1:0]          now_time,
  input  logic [tdb_pkg::PRESET_W-1:0]  preset_ms,
  output tdb_pkg::tdb_upd_t             upd
);

  logic [TIME_BITS-1:0] elapsed;
  logic                 reached;

  // wrapping difference modulo 2^TIME_BITS
  assign elapsed = now_time - start_time;
  assign reached = elapsed >= TIME_BITS'(preset_ms);

  always_comb begin
    upd = '0;
    if (in_range) begin
      if (!enable) begin
        upd.wr_flags = 1'b1;
      end else if (!sess) begin
        upd.wr_flags = 1'b1;
        upd.sess_val = 1'b1;
        upd.start_wr = 1'b1;
      end else if (done) begin
        upd.done_res = 1'b1;
      end else if (reached) begin
        upd.wr_flags = 1'b1;
        upd.sess_val = 1'b1;
        upd.done_val = 1'b1;
        upd.done_res = 1'b1;
      end
    end
  end

endmodule

[hw/rtl/on_delay_timer_bank.sv]
// top level of the on-delay timer bank: read stage, evaluate stage, flag store
// a transaction accepted at one edge gives its result strobe in the next cycle
// throughput: one transaction per cycle unless busy; the start time read is the read stage
// a back-to-back access to the same timer takes the start time from a forwarding register
// reset: synchronous rst_n clears session and done flags of all timers; busy is high in reset
// results cannot be stalled: each strobe lasts exactly one cycle
module on_delay_timer_bank #(
  parameter int TIMERS    = tdb_pkg::TIMERS_DEF,
  parameter int TIME_BITS = tdb_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [tdb_pkg::INDEX_W-1:0]   in_timer_index,
  input  logic                          in_enable,
  input  logic [tdb_pkg::PRESET_W-1:0]  in_preset_ms,
  input  logic [tdb_pkg::NOW_W-1:0]     in_now_ms,
  output logic                          out_strobe,
  output logic                          out_done_res
);

  localparam int AW    = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int IDX_X = (AW > tdb_pkg::INDEX_W) ? AW : tdb_pkg::INDEX_W;
  localparam int IDX_C = IDX_X + 1;
  localparam int NOW_X = (TIME_BITS > tdb_pkg::NOW_W) ? TIME_BITS : tdb_pkg::NOW_W;

  logic                  accept;
  logic [IDX_X-1:0]      idx_ext;
  logic [AW-1:0]         in_addr;
  logic                  in_range;
  logic [NOW_X-1:0]      now_ext;
  logic [TIME_BITS-1:0]  in_time;

  logic                  busy_r;
  logic                  s1_vld_r;
  logic [AW-1:0]         s1_addr_r;
  logic                  s1_inr_r;
  logic                  s1_en_r;
  logic [tdb_pkg::PRESET_W-1:0] s1_preset_r;
  logic [TIME_BITS-1:0]  s1_now_r;
  logic                  s1_fwd_hit_r;
  logic [TIME_BITS-1:0]  s1_fwd_data_r;

  logic                  sess_r [TIMERS];
  logic                  done_r [TIMERS];

  logic [TIME_BITS-1:0]  mem_q;
  logic [TIME_BITS-1:0]  s1_start;
  logic                  s1_sess;
  logic                  s1_done;
  logic                  mem_wr;
  logic                  fwd_hit;
  tdb_pkg::tdb_upd_t     upd;

  assign accept   = start && !busy_r;
  assign busy     = busy_r;
  assign idx_ext  = IDX_X'(in_timer_index);
  assign in_addr  = idx_ext[AW-1:0];
  // one extra bit so a bank that fills the whole index range still compares right
  assign in_range = {1'b0, idx_ext} < IDX_C'(TIMERS);
  assign now_ext  = NOW_X'(in_now_ms);
  assign in_time  = now_ext[TIME_BITS-1:0];

  assign mem_wr  = s1_vld_r && upd.start_wr;
  assign fwd_hit = mem_wr && (s1_addr_r == in_addr);

  tdb_start_mem #(
    .DEPTH  (TIMERS),
    .DATA_W (TIME_BITS),
    .ADDR_W (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (s1_addr_r),
    .wr_data (s1_now_r),
    .rd_en   (accept && in_range),
    .rd_addr (in_addr),
    .rd_data (mem_q)
  );

  // memory read sees old data when the previous transaction wrote the same entry
  assign s1_start = s1_fwd_hit_r ? s1_fwd_data_r : mem_q;
  assign s1_sess  = s1_inr_r ? sess_r[s1_addr_r] : 1'b0;
  assign s1_done  = s1_inr_r ? done_r[s1_addr_r] : 1'b0;

  tdb_eval #(
    .TIME_BITS (TIME_BITS)
  ) u_eval (
    .in_range   (s1_inr_r),
    .enable     (s1_en_r),
    .sess       (s1_sess),
    .done       (s1_done),
    .start_time (s1_start),
    .now_time   (s1_now_r),
    .preset_ms  (s1_preset_r),
    .upd        (upd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b1;
      s1_vld_r <= 1'b0;
    end else begin
      busy_r   <= 1'b0;
      s1_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr_r     <= in_addr;
      s1_inr_r      <= in_range;
      s1_en_r       <= in_enable;
      s1_preset_r   <= in_preset_ms;
      s1_now_r      <= in_time;
      s1_fwd_hit_r  <= fwd_hit;
      s1_fwd_data_r <= s1_now_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TIMERS; i++) begin
        sess_r[i] <= 1'b0;
        done_r[i] <= 1'b0;
      end
    end else if (s1_vld_r && upd.wr_flags) begin
      sess_r[s1_addr_r] <= upd.sess_val;
      done_r[s1_addr_r] <= upd.done_val;
    end
  end

  assign out_strobe   = s1_vld_r;
  assign out_done_res = s1_vld_r && upd.done_res;

`ifndef SYNTHESIS
  a_strobe_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy))
    else $error("result strobe without an accepted transaction");

  a_disabled_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !s1_en_r) |-> !out_done_res)
    else $error("done reported for a disabled timer");

  a_fwd_needs_prev: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && s1_fwd_hit_r) |-> $past(out_strobe))
    else $error("start time forwarded without a preceding transaction");

  a_start_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && upd.start_wr) |=> !done_r[$past(s1_addr_r)])
    else $error("done flag set at session start");
`endif

endmodule

[tb/on_delay_timer_bank_tb.sv]
`timescale 1ns / 100ps
// self-checking testbench for the on-delay timer bank: directed and random accesses
module on_delay_timer_bank_tb;

  localparam int NTIMERS         = tdb_pkg::TIMERS_DEF;
  localparam int INDEX_W         = tdb_pkg::INDEX_W;
  localparam int PRESET_W        = tdb_pkg::PRESET_W;
  localparam int NOW_W           = tdb_pkg::NOW_W;
  localparam int RANDOM_ACCESSES = 2000;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int MAX_REPORTS     = 10;

  typedef struct {
    logic [INDEX_W-1:0] timer;
    logic               done;
  } done_expect_t;

  // tracks every timer's session and holds the done bits still to come
  class ton_bank_scoreboard;
    logic [NOW_W-1:0] start_ts [NTIMERS];
    bit               running  [NTIMERS];
    bit               expired  [NTIMERS];
    done_expect_t     pending_done [$];
    int               mismatches;

    function new();
      for (int i = 0; i < NTIMERS; i++) begin
        start_ts[i] = '0;
        running[i]  = 1'b0;
        expired[i]  = 1'b0;
      end
      mismatches = 0;
    endfunction

    function void note_access(logic [INDEX_W-1:0] idx, logic en,
                              logic [PRESET_W-1:0] preset, logic [NOW_W-1:0] now);
      logic [NOW_W-1:0] elapsed;
      done_expect_t     exp_item;
      exp_item.timer = idx;
      exp_item.done  = 1'b0;
      if (int'(idx) < NTIMERS) begin
        if (!en) begin
          running[idx] = 1'b0;
          expired[idx] = 1'b0;
        end else if (!running[idx]) begin
          start_ts[idx] = now;
          running[idx]  = 1'b1;
          expired[idx]  = 1'b0;
        end else if (expired[idx]) begin
          exp_item.done = 1'b1;
        end else begin
          // elapsed time wraps with the millisecond counter
          elapsed = now - start_ts[idx];
          if (elapsed >= NOW_W'(preset)) begin
            expired[idx]  = 1'b1;
            exp_item.done = 1'b1;
          end
        end
      end
      pending_done.push_back(exp_item);
    endfunction

    function void flag_mismatch(string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, what);
    endfunction

    function void check_done(logic got);
      done_expect_t exp_item;
      if (pending_done.size() == 0) begin
        flag_mismatch($sformatf("done strobe with no transaction outstanding, got %b", got));
        return;
      end
      exp_item = pending_done.pop_front();
      if (got !== exp_item.done)
        flag_mismatch($sformatf("timer %0d done_res expected %b got %b",
                                exp_item.timer, exp_item.done, got));
    endfunction

    function int outstanding();
      return pending_done.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [INDEX_W-1:0]  in_timer_index;
  logic                in_enable;
  logic [PRESET_W-1:0] in_preset_ms;
  logic [NOW_W-1:0]    in_now_ms;
  logic                out_strobe;
  logic                out_done_res;

  ton_bank_scoreboard sb = new();
  int cycles = 0;
  int gap_seq = 0;

  on_delay_timer_bank DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_timer_index (in_timer_index),
    .in_enable      (in_enable),
    .in_preset_ms   (in_preset_ms),
    .in_now_ms      (in_now_ms),
    .out_strobe     (out_strobe),
    .out_done_res   (out_done_res)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_done(out_done_res);
  end

  // random spacing, with back-to-back stretches every so often
  function automatic int pick_gap();
    gap_seq++;
    if ((gap_seq % 150) >= 110) return 0;
    return $urandom_range(0, 14);
  endfunction

  task automatic issue_access(input logic [INDEX_W-1:0] idx, input logic en,
                              input logic [PRESET_W-1:0] preset,
                              input logic [NOW_W-1:0] now, input int gap);
    repeat (gap) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start          = 1'b1;
    in_timer_index = idx;
    in_enable      = en;
    in_preset_ms   = preset;
    in_now_ms      = now;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_access(idx, en, preset, now);
  endtask

  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    logic [NOW_W-1:0]    clock_ms;
    logic [NOW_W-1:0]    stamp;
    logic [PRESET_W-1:0] preset;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_timer_index = '0;
    in_enable      = 1'b0;
    in_preset_ms   = '0;
    in_now_ms      = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // zero preset: first call only opens the session, second one finishes
    issue_access(4'd0, 1'b1, 15'd0, 32'h0000_0000, pick_gap());
    issue_access(4'd0, 1'b1, 15'd0, 32'h0000_0000, pick_gap());
    issue_access(4'd0, 1'b1, 15'h7FFF, 32'h0000_0000, pick_gap());
    issue_access(4'd0, 1'b0, 15'h7FFF, 32'hFFFF_FFFF, pick_gap());
    // session across the wrap of the millisecond counter, max preset
    issue_access(4'd15, 1'b1, 15'h7FFF, 32'hFFFF_FFF0, pick_gap());
    issue_access(4'd15, 1'b1, 15'h7FFF, 32'h0000_7FEE, pick_gap());
    issue_access(4'd15, 1'b1, 15'h7FFF, 32'h0000_7FEF, pick_gap());
    issue_access(4'd15, 1'b1, 15'h7FFF, 32'hFFFF_FFF0, pick_gap());
    issue_access(4'd15, 1'b0, 15'd0, 32'd0, pick_gap());
    // waiting, interleaved timers, preset lowered mid session
    issue_access(4'd15, 1'b1, 15'd5, 32'd100, pick_gap());
    issue_access(4'd15, 1'b1, 15'd5, 32'd104, pick_gap());
    issue_access(4'd7, 1'b1, 15'd3, 32'd1000, pick_gap());
    issue_access(4'd15, 1'b1, 15'd3, 32'd104, pick_gap());
    issue_access(4'd7, 1'b0, 15'd3, 32'd1001, pick_gap());
    issue_access(4'd7, 1'b0, 15'd3, 32'd1002, pick_gap());
    // time stepping backwards looks like a huge elapsed time
    issue_access(4'd7, 1'b1, 15'd10, 32'd2000, pick_gap());
    issue_access(4'd7, 1'b1, 15'd10, 32'd1999, pick_gap());
    issue_access(4'd10, 1'b1, 15'h5555, 32'hAAAA_AAAA, pick_gap());
    issue_access(4'd10, 1'b1, 15'h2AAA, 32'hAAAA_D554, pick_gap());
    issue_access(4'd10, 1'b1, 15'h2AAA, 32'h5555_5555, pick_gap());

    clock_ms = $urandom;
    for (int i = 0; i < RANDOM_ACCESSES; i++) begin
      if (i == RANDOM_ACCESSES / 2) drain_results();
      clock_ms = clock_ms + $urandom_range(0, 24);
      stamp    = clock_ms;
      // a stray time stamp now and then
      if ($urandom_range(0, 49) == 0) stamp = $urandom;
      if ($urandom_range(0, 9) == 0) preset = PRESET_W'($urandom_range(0, 32767));
      else preset = PRESET_W'($urandom_range(0, 400));
      issue_access(INDEX_W'($urandom_range(0, NTIMERS - 1)),
                   ($urandom_range(0, 99) < 85), preset, stamp, pick_gap());
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
